@@ rtl/core/nns_pkg.sv @@
// Shared types, constants and register codes of the nearest-neighbour scaler.
`default_nettype none

package nns_pkg;

    // Sizes of the stored source image and of the scaled image.
    localparam int MAX_SRC_WIDTH_DEF  = 256;
    localparam int MAX_SRC_HEIGHT_DEF = 256;
    localparam int MAX_DST_SIZE_DEF   = 1024;

    // Fixed field widths.
    localparam int COORD_W   = 10;
    localparam int PIXEL_W   = 8;
    localparam int SRC_CFG_W = 9;
    localparam int DST_CFG_W = 11;
    localparam int CFG_DATA_W = DST_CFG_W;
    localparam int CFG_IDX_W  = 8;

    // Coordinate times (source size - 1) before the division.
    localparam int NUM_W = COORD_W + SRC_CFG_W;

    // Register values after reset.
    localparam logic [SRC_CFG_W-1:0] SRC_WIDTH_RST  = 9'd256;
    localparam logic [SRC_CFG_W-1:0] SRC_HEIGHT_RST = 9'd256;
    localparam logic [DST_CFG_W-1:0] DST_WIDTH_RST  = 11'd200;
    localparam logic [DST_CFG_W-1:0] DST_HEIGHT_RST = 11'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 8'd0,
        CFG_SRC_HEIGHT = 8'd1,
        CFG_DST_WIDTH  = 8'd2,
        CFG_DST_HEIGHT = 8'd3
    } t_cfg_idx;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_READ  = 1'b1
    } t_action;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIXEL_W-1:0] pixel;
    } t_in_item;

    typedef struct packed {
        logic [PIXEL_W-1:0] out_pixel;
        logic               error;
    } t_out_item;

    typedef struct packed {
        logic [SRC_CFG_W-1:0] src_width;
        logic [SRC_CFG_W-1:0] src_height;
        logic [DST_CFG_W-1:0] dst_width;
        logic [DST_CFG_W-1:0] dst_height;
    } t_cfg;

    // Per-item control that travels down the pipeline.
    typedef struct packed {
        logic               rd;
        logic               err;
        logic               wen;
        logic [PIXEL_W-1:0] pix;
    } t_ctl;

endpackage

`default_nettype wire

@@ rtl/core/nearest_neighbor_scaler.sv @@
// Top level of the nearest-neighbour scaler: registers, pipeline and result stage.
//
//  Channel   Direction  Ports                               Transfer when
//  ------------------------------------------------------------------------------
//  command   in         start, busy, i_item                 start high, busy low
//  result    out        o_valid, o_result                   o_valid high (one cycle)
//  config    in         i_cfg_we, i_cfg_idx, i_cfg_data     i_cfg_we high
//
// One item is taken every clock and the receiver cannot stall; busy is high only in reset.
// A read gives its result after passing through its pipeline stages: one entry stage,
// STEPS divider stages (one per quotient bit; STEPS is the bit count of the larger source
// dimension, 8 at the default sizes), then the address, memory and output stages.
// Writes pass down the same pipeline and update the frame store at the memory
// stage, so reads and writes act on it in transfer order. Writes give no result.
// Reset clears the valid bits and registers only; the frame store is not cleared.
`default_nettype none

module nearest_neighbor_scaler #(
    parameter int MAX_SRC_WIDTH  = nns_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = nns_pkg::MAX_SRC_HEIGHT_DEF,
    parameter int MAX_DST_SIZE   = nns_pkg::MAX_DST_SIZE_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire nns_pkg::t_in_item                i_item,
    output logic                                  o_valid,
    output nns_pkg::t_out_item                    o_result,
    input  wire logic                             i_cfg_we,
    input  wire logic [nns_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [nns_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int RW      = $clog2(MAX_SRC_HEIGHT);
    localparam int CW      = $clog2(MAX_SRC_WIDTH);
    localparam int STEPS   = (RW > CW) ? RW : CW;
    localparam int AUX_W   = RW + CW;
    localparam int LATENCY = STEPS + 4;
    localparam int NW      = nns_pkg::NUM_W;
    localparam int SW      = nns_pkg::SRC_CFG_W;
    localparam int DW      = nns_pkg::DST_CFG_W;

    logic                          accept;
    nns_pkg::t_cfg                 r_cfg;

    logic                          f_vld;
    nns_pkg::t_ctl                 f_ctl;
    logic [NW-1:0]                 f_num_r;
    logic [NW-1:0]                 f_num_c;
    logic [RW-1:0]                 f_wrow;
    logic [CW-1:0]                 f_wcol;

    logic                          d_vld;
    nns_pkg::t_ctl                 d_ctl;
    logic [STEPS-1:0]              d_q_r;
    logic [STEPS-1:0]              d_q_c;
    logic [AUX_W-1:0]              d_aux;

    logic                          m_vld;
    logic                          m_err;
    logic [nns_pkg::PIXEL_W-1:0]   m_pix;

    logic                          r_valid;
    nns_pkg::t_out_item            r_result;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= nns_pkg::SRC_WIDTH_RST;
            r_cfg.src_height <= nns_pkg::SRC_HEIGHT_RST;
            r_cfg.dst_width  <= nns_pkg::DST_WIDTH_RST;
            r_cfg.dst_height <= nns_pkg::DST_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nns_pkg::CFG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data[SW-1:0];
                nns_pkg::CFG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_data[SW-1:0];
                nns_pkg::CFG_DST_WIDTH:  r_cfg.dst_width  <= i_cfg_data[DW-1:0];
                nns_pkg::CFG_DST_HEIGHT: r_cfg.dst_height <= i_cfg_data[DW-1:0];
                default: begin
                end
            endcase
        end
    end

    nns_front #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_DST_SIZE   (MAX_DST_SIZE),
        .RW             (RW),
        .CW             (CW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .o_vld    (f_vld),
        .o_ctl    (f_ctl),
        .o_num_r  (f_num_r),
        .o_num_c  (f_num_c),
        .o_wrow   (f_wrow),
        .o_wcol   (f_wcol)
    );

    // Divisors are dst sizes less one; user holds them still as items flow; unenforced.
    nns_div_pipe #(
        .STEPS (STEPS),
        .AUX_W (AUX_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_ctl   (f_ctl),
        .i_num_r (f_num_r),
        .i_num_c (f_num_c),
        .i_den_r (r_cfg.dst_height - 11'd1),
        .i_den_c (r_cfg.dst_width - 11'd1),
        .i_aux   ({f_wrow, f_wcol}),
        .o_vld   (d_vld),
        .o_ctl   (d_ctl),
        .o_q_r   (d_q_r),
        .o_q_c   (d_q_c),
        .o_aux   (d_aux)
    );

    nns_frame_store #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .STEPS          (STEPS),
        .RW             (RW),
        .CW             (CW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (d_vld),
        .i_ctl   (d_ctl),
        .i_q_r   (d_q_r),
        .i_q_c   (d_q_c),
        .i_wrow  (d_aux[AUX_W-1:CW]),
        .i_wcol  (d_aux[CW-1:0]),
        .o_vld   (m_vld),
        .o_err   (m_err),
        .o_pix   (m_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.out_pixel <= m_err ? '0 : m_pix;
        r_result.error     <= m_err;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.action == nns_pkg::ACT_READ) |-> ##LATENCY o_valid)
        else $error("read transfer without a result");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.action == nns_pkg::ACT_WRITE) |-> ##LATENCY !o_valid)
        else $error("write transfer produced a result");

    a_error_pixel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.error |-> (o_result.out_pixel == '0))
        else $error("error result carries a nonzero pixel");

endmodule

`default_nettype wire

@@ rtl/core/nns_front.sv @@
// Entry stage: range checks, write qualification and the two scaling products.
`default_nettype none

module nns_front #(
    parameter int MAX_SRC_WIDTH  = nns_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = nns_pkg::MAX_SRC_HEIGHT_DEF,
    parameter int MAX_DST_SIZE   = nns_pkg::MAX_DST_SIZE_DEF,
    parameter int RW             = $clog2(MAX_SRC_HEIGHT),
    parameter int CW             = $clog2(MAX_SRC_WIDTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire nns_pkg::t_in_item         i_item,
    input  wire nns_pkg::t_cfg             i_cfg,
    output logic                           o_vld,
    output nns_pkg::t_ctl                  o_ctl,
    output logic [nns_pkg::NUM_W-1:0]      o_num_r,
    output logic [nns_pkg::NUM_W-1:0]      o_num_c,
    output logic [RW-1:0]                  o_wrow,
    output logic [CW-1:0]                  o_wcol
);

    localparam int NW = nns_pkg::NUM_W;

    logic                 src_ok;
    logic                 dst_bad;
    logic                 is_read;
    nns_pkg::t_ctl        n_ctl;
    logic [NW-1:0]        n_num_r;
    logic [NW-1:0]        n_num_c;

    logic                 r_vld;
    nns_pkg::t_ctl        r_ctl;
    logic [NW-1:0]        r_num_r;
    logic [NW-1:0]        r_num_c;
    logic [RW-1:0]        r_wrow;
    logic [CW-1:0]        r_wcol;

    always_comb begin
        is_read = (i_item.action == nns_pkg::ACT_READ);
        src_ok  = (i_cfg.src_width != '0) && (32'(i_cfg.src_width) <= MAX_SRC_WIDTH) &&
                  (i_cfg.src_height != '0) && (32'(i_cfg.src_height) <= MAX_SRC_HEIGHT);
        dst_bad = (i_cfg.dst_width < 11'd2) || (i_cfg.dst_height < 11'd2) ||
                  (32'(i_cfg.dst_width) > MAX_DST_SIZE) ||
                  (32'(i_cfg.dst_height) > MAX_DST_SIZE) ||
                  (11'(i_item.row) >= i_cfg.dst_height) ||
                  (11'(i_item.col) >= i_cfg.dst_width);

        n_ctl.rd  = is_read;
        n_ctl.err = is_read && (!src_ok || dst_bad);
        n_ctl.wen = !is_read && src_ok &&
                    (i_item.row < 10'(i_cfg.src_height)) &&
                    (i_item.col < 10'(i_cfg.src_width));
        n_ctl.pix = i_item.pixel;

        n_num_r = NW'(i_item.row) * NW'(i_cfg.src_height - 9'd1);
        n_num_c = NW'(i_item.col) * NW'(i_cfg.src_width - 9'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl   <= n_ctl;
        r_num_r <= n_num_r;
        r_num_c <= n_num_c;
        r_wrow  <= RW'(i_item.row);
        r_wcol  <= CW'(i_item.col);
    end

    assign o_vld   = r_vld;
    assign o_ctl   = r_ctl;
    assign o_num_r = r_num_r;
    assign o_num_c = r_num_c;
    assign o_wrow  = r_wrow;
    assign o_wcol  = r_wcol;

endmodule

`default_nettype wire

@@ rtl/core/nns_div_pipe.sv @@
// Pipelined restoring divider for row and column, one quotient bit per stage.
`default_nettype none

module nns_div_pipe #(
    parameter int STEPS = 8,
    parameter int AUX_W = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire nns_pkg::t_ctl                 i_ctl,
    input  wire logic [nns_pkg::NUM_W-1:0]     i_num_r,
    input  wire logic [nns_pkg::NUM_W-1:0]     i_num_c,
    input  wire logic [nns_pkg::DST_CFG_W-1:0] i_den_r,
    input  wire logic [nns_pkg::DST_CFG_W-1:0] i_den_c,
    input  wire logic [AUX_W-1:0]              i_aux,
    output logic                               o_vld,
    output nns_pkg::t_ctl                      o_ctl,
    output logic [STEPS-1:0]                   o_q_r,
    output logic [STEPS-1:0]                   o_q_c,
    output logic [AUX_W-1:0]                   o_aux
);

    localparam int NW = nns_pkg::NUM_W;
    localparam int EW = NW + STEPS + nns_pkg::DST_CFG_W;

    logic [STEPS-1:0]  r_vld;
    nns_pkg::t_ctl     r_ctl   [STEPS];
    logic [NW-1:0]     r_rem_r [STEPS];
    logic [NW-1:0]     r_rem_c [STEPS];
    logic [STEPS-1:0]  r_q_r   [STEPS];
    logic [STEPS-1:0]  r_q_c   [STEPS];
    logic [AUX_W-1:0]  r_aux   [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam int K = STEPS - 1 - s;

        logic              vld_in;
        nns_pkg::t_ctl     ctl_in;
        logic [NW-1:0]     rem_r_in;
        logic [NW-1:0]     rem_c_in;
        logic [STEPS-1:0]  q_r_in;
        logic [STEPS-1:0]  q_c_in;
        logic [AUX_W-1:0]  aux_in;
        logic [EW-1:0]     sub_r;
        logic [EW-1:0]     sub_c;
        logic              ge_r;
        logic              ge_c;

        if (s == 0) begin : g_first
            assign vld_in   = i_vld;
            assign ctl_in   = i_ctl;
            assign rem_r_in = i_num_r;
            assign rem_c_in = i_num_c;
            assign q_r_in   = '0;
            assign q_c_in   = '0;
            assign aux_in   = i_aux;
        end else begin : g_next
            assign vld_in   = r_vld[s-1];
            assign ctl_in   = r_ctl[s-1];
            assign rem_r_in = r_rem_r[s-1];
            assign rem_c_in = r_rem_c[s-1];
            assign q_r_in   = r_q_r[s-1];
            assign q_c_in   = r_q_c[s-1];
            assign aux_in   = r_aux[s-1];
        end

        // For a good read the quotient stays below 2**STEPS, so a trial at this weight is exact.
        assign sub_r = EW'(i_den_r) << K;
        assign sub_c = EW'(i_den_c) << K;
        assign ge_r  = (EW'(rem_r_in) >= sub_r);
        assign ge_c  = (EW'(rem_c_in) >= sub_c);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_ctl[s]   <= ctl_in;
            r_aux[s]   <= aux_in;
            r_rem_r[s] <= ge_r ? NW'(EW'(rem_r_in) - sub_r) : rem_r_in;
            r_rem_c[s] <= ge_c ? NW'(EW'(rem_c_in) - sub_c) : rem_c_in;
            r_q_r[s]   <= q_r_in | (ge_r ? (STEPS'(1) << K) : '0);
            r_q_c[s]   <= q_c_in | (ge_c ? (STEPS'(1) << K) : '0);
        end
    end

    assign o_vld = r_vld[STEPS-1];
    assign o_ctl = r_ctl[STEPS-1];
    assign o_q_r = r_q_r[STEPS-1];
    assign o_q_c = r_q_c[STEPS-1];
    assign o_aux = r_aux[STEPS-1];

    // A good read leaves a remainder below the divisor in both lanes.
    a_rem_r_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STEPS-1] && r_ctl[STEPS-1].rd && !r_ctl[STEPS-1].err |->
        (EW'(r_rem_r[STEPS-1]) < EW'(i_den_r)))
        else $error("row remainder not below divisor");

    a_rem_c_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STEPS-1] && r_ctl[STEPS-1].rd && !r_ctl[STEPS-1].err |->
        (EW'(r_rem_c[STEPS-1]) < EW'(i_den_c)))
        else $error("column remainder not below divisor");

endmodule

`default_nettype wire

@@ rtl/core/nns_frame_store.sv @@
// Address stage and frame store; writes and reads meet the memory in item order.
`default_nettype none

module nns_frame_store #(
    parameter int MAX_SRC_WIDTH  = nns_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = nns_pkg::MAX_SRC_HEIGHT_DEF,
    parameter int STEPS          = 8,
    parameter int RW             = $clog2(MAX_SRC_HEIGHT),
    parameter int CW             = $clog2(MAX_SRC_WIDTH)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_vld,
    input  wire nns_pkg::t_ctl               i_ctl,
    input  wire logic [STEPS-1:0]            i_q_r,
    input  wire logic [STEPS-1:0]            i_q_c,
    input  wire logic [RW-1:0]               i_wrow,
    input  wire logic [CW-1:0]               i_wcol,
    output logic                             o_vld,
    output logic                             o_err,
    output logic [nns_pkg::PIXEL_W-1:0]      o_pix
);

    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ROW_PITCH = AW'(MAX_SRC_WIDTH);

    logic [RW-1:0]                   row_sel;
    logic [CW-1:0]                   col_sel;
    logic [AW-1:0]                   n_addr;

    logic                            r_we;
    logic                            r_re;
    logic                            r_a_err;
    logic [AW-1:0]                   r_addr;
    logic [nns_pkg::PIXEL_W-1:0]     r_wpix;
    logic                            r_m_vld;
    logic                            r_m_err;
    logic [nns_pkg::PIXEL_W-1:0]     r_rdata;
    logic [nns_pkg::PIXEL_W-1:0]     r_mem [DEPTH];

    always_comb begin
        row_sel = i_ctl.rd ? RW'(i_q_r) : i_wrow;
        col_sel = i_ctl.rd ? CW'(i_q_c) : i_wcol;
        n_addr  = AW'(AW'(row_sel) * ROW_PITCH + AW'(col_sel));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we    <= 1'b0;
            r_re    <= 1'b0;
            r_m_vld <= 1'b0;
        end else begin
            r_we    <= i_vld && !i_ctl.rd && i_ctl.wen;
            r_re    <= i_vld && i_ctl.rd;
            r_m_vld <= r_re;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_wpix  <= i_ctl.pix;
        r_a_err <= i_ctl.err;
        r_m_err <= r_a_err;
    end

    // Only one item sits at the memory stage, so a write and a read never collide.
    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_addr] <= r_wpix;
        end
        r_rdata <= r_mem[r_addr];
    end

    assign o_vld = r_m_vld;
    assign o_err = r_m_err;
    assign o_pix = r_rdata;

endmodule

`default_nettype wire
